// ----- rtl/core/cls_pkg.sv -----
// Shared types and constants for the CAN loopback self-test block.
package cls_pkg;

    // Configuration register indexes
    localparam logic [2:0] REG_SEND_PERIOD    = 3'd0;
    localparam logic [2:0] REG_REPLY_TIMEOUT  = 3'd1;
    localparam logic [2:0] REG_REPORT_PERIOD  = 3'd2;
    localparam logic [2:0] REG_STANDARD_ID    = 3'd3;
    localparam logic [2:0] REG_EXTENDED_ID    = 3'd4;

    // Reset values of the configuration registers
    localparam logic [15:0] SEND_PERIOD_RST   = 16'd1000;
    localparam logic [15:0] REPLY_TIMEOUT_RST = 16'd100;
    localparam logic [31:0] REPORT_PERIOD_RST = 32'd10000;
    localparam logic [10:0] STANDARD_ID_RST   = 11'h7E1;
    localparam logic [28:0] EXTENDED_ID_RST   = 29'h18DAF1E1;

    // Item and result kinds
    localparam logic MODE_TICK   = 1'b0;
    localparam logic MODE_FRAME  = 1'b1;
    localparam logic KIND_FRAME  = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    // Test frame tail bytes CA FE 55 AA and the required length
    localparam logic [31:0] TAIL_PATTERN = 32'hCAFE55AA;
    localparam logic [3:0]  FRAME_LEN    = 4'd8;

    // Result queue
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    // Port widths: fields packed from bit 0, padded to whole bytes
    localparam int S_TDATA_W = 104;
    localparam int M_TDATA_W = 288;

    typedef struct packed {
        logic        mode;
        logic        tx_accept;
        logic [28:0] rx_id;
        logic        rx_ext;
        logic        rx_rtr;
        logic [3:0]  rx_len;
        logic [63:0] rx_data;
    } in_item_t;

    typedef struct packed {
        logic        kind;
        logic        last;
        logic [28:0] tx_id;
        logic        tx_ext;
        logic [63:0] tx_data;
        logic        pass;
        logic [31:0] period_sent;
        logic [31:0] period_ok;
        logic [31:0] period_lost;
        logic [31:0] period_bad;
        logic [31:0] total_ok;
        logic [31:0] total_fail;
    } res_t;

    typedef struct packed {
        logic        valid;
        logic [2:0]  index;
        logic [31:0] data;
    } cfg_wr_t;

endpackage

// ----- rtl/core/cls_res_fifo.sv -----
// Small result queue that takes up to two results per cycle and gives one.
module cls_res_fifo
    import cls_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic [1:0] push_n,
    input  res_t       push0,
    input  res_t       push1,
    input  logic       pop,
    output res_t       head,
    output logic       not_empty,
    output logic       room2
);

    res_t             mem_reg [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    // Advance pointers and fill count
    always_comb begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push_n);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        cnt_next    = cnt_reg + CNT_W'(push_n) - CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Store new results in order
    always_ff @(posedge aclk) begin
        if (push_n != 2'd0) begin
            mem_reg[wr_ptr_reg] <= push0;
        end
        if (push_n == 2'd2) begin
            mem_reg[wr_ptr_reg + PTR_W'(1)] <= push1;
        end
    end

    assign head      = mem_reg[rd_ptr_reg];
    assign not_empty = (cnt_reg != '0);
    assign room2     = (cnt_reg <= CNT_W'(FIFO_DEPTH - 2));

endmodule

// ----- rtl/core/cls_engine.sv -----
// Test state, configuration registers and per-item update logic.
module cls_engine
    import cls_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  cfg_wr_t  cfg_wr,
    input  logic     fire,
    input  in_item_t item,
    output logic [1:0] push_n,
    output res_t     res0,
    output res_t     res1
);

    logic [15:0] send_period_reg, send_period_next;
    logic [15:0] reply_timeout_reg, reply_timeout_next;
    logic [31:0] report_period_reg, report_period_next;
    logic [10:0] standard_id_reg, standard_id_next;
    logic [28:0] extended_id_reg, extended_id_next;

    logic [31:0] tick_now_reg, tick_now_next;
    logic [31:0] next_send_reg, next_send_next;
    logic [31:0] next_report_reg, next_report_next;
    logic [31:0] sent_time_reg, sent_time_next;
    logic        awaiting_reg, awaiting_next;
    logic [31:0] sequence_reg, sequence_next;
    logic [31:0] count_sent_reg, count_sent_next;
    logic [31:0] count_ok_reg, count_ok_next;
    logic [31:0] count_lost_reg, count_lost_next;
    logic [31:0] count_bad_reg, count_bad_next;
    logic [31:0] sum_ok_reg, sum_ok_next;
    logic [31:0] sum_fail_reg, sum_fail_next;

    always_comb begin
        logic [31:0] t1;
        logic [31:0] elapsed;
        logic [31:0] send_diff;
        logic [31:0] rep_diff;
        logic        timed_out;
        logic        still_out;
        logic        send_now;
        logic        refused;
        logic        rpt_now;
        logic [31:0] seq1;
        logic [31:0] sent_c;
        logic [31:0] lost_c;
        logic [31:0] fail_c;
        logic [28:0] cur_id;
        logic        match;
        logic        rearm;

        send_period_next   = send_period_reg;
        reply_timeout_next = reply_timeout_reg;
        report_period_next = report_period_reg;
        standard_id_next   = standard_id_reg;
        extended_id_next   = extended_id_reg;
        tick_now_next      = tick_now_reg;
        next_send_next     = next_send_reg;
        next_report_next   = next_report_reg;
        sent_time_next     = sent_time_reg;
        awaiting_next      = awaiting_reg;
        sequence_next      = sequence_reg;
        count_sent_next    = count_sent_reg;
        count_ok_next      = count_ok_reg;
        count_lost_next    = count_lost_reg;
        count_bad_next     = count_bad_reg;
        sum_ok_next        = sum_ok_reg;
        sum_fail_next      = sum_fail_reg;
        push_n             = 2'd0;
        res0               = '0;
        res1               = '0;
        rearm              = 1'b0;

        // Decode register writes
        if (cfg_wr.valid) begin
            unique case (cfg_wr.index)
                REG_SEND_PERIOD: begin
                    send_period_next = cfg_wr.data[15:0];
                    rearm            = 1'b1;
                end
                REG_REPLY_TIMEOUT: reply_timeout_next = cfg_wr.data[15:0];
                REG_REPORT_PERIOD: begin
                    report_period_next = cfg_wr.data;
                    rearm              = 1'b1;
                end
                REG_STANDARD_ID: standard_id_next = cfg_wr.data[10:0];
                REG_EXTENDED_ID: extended_id_next = cfg_wr.data[28:0];
                default: ;
            endcase
        end
        // Re-arm both schedules from the current tick
        if (rearm) begin
            next_send_next   = tick_now_reg + {16'd0, send_period_next};
            next_report_next = tick_now_reg + report_period_next
                               + {17'd0, send_period_next[15:1]};
        end

        // Check a returned frame against the outstanding one
        cur_id = sequence_reg[0] ? extended_id_reg : {18'd0, standard_id_reg};
        match  = (item.rx_id == cur_id) && (item.rx_ext == sequence_reg[0])
                 && !item.rx_rtr && (item.rx_len == FRAME_LEN)
                 && (item.rx_data == {sequence_reg, TAIL_PATTERN});

        // Tick path: timeout, send, report
        t1        = tick_now_reg + 32'd1;
        elapsed   = t1 - sent_time_reg;
        timed_out = awaiting_reg && (elapsed >= {16'd0, reply_timeout_reg});
        still_out = awaiting_reg && !timed_out;
        send_diff = t1 - next_send_reg;
        send_now  = !still_out && !send_diff[31];
        refused   = send_now && !item.tx_accept;
        seq1      = sequence_reg + 32'd1;
        sent_c    = count_sent_reg + {31'd0, send_now};
        lost_c    = count_lost_reg + {31'd0, timed_out} + {31'd0, refused};
        fail_c    = sum_fail_reg + {31'd0, timed_out} + {31'd0, refused};
        rep_diff  = t1 - next_report_reg;
        rpt_now   = !rep_diff[31];

        if (fire) begin
            if (item.mode == MODE_FRAME) begin
                if (!awaiting_reg) begin
                    count_bad_next = count_bad_reg + 32'd1;
                end else if (match) begin
                    count_ok_next = count_ok_reg + 32'd1;
                    sum_ok_next   = sum_ok_reg + 32'd1;
                end else begin
                    count_bad_next = count_bad_reg + 32'd1;
                    sum_fail_next  = sum_fail_reg + 32'd1;
                end
                awaiting_next = 1'b0;
            end else begin
                tick_now_next   = t1;
                awaiting_next   = still_out;
                count_lost_next = lost_c;
                sum_fail_next   = fail_c;
                count_sent_next = sent_c;
                if (send_now) begin
                    next_send_next = next_send_reg + {16'd0, send_period_reg};
                    sequence_next  = seq1;
                    if (item.tx_accept) begin
                        awaiting_next  = 1'b1;
                        sent_time_next = t1;
                    end
                end

                // Build the frame result, then the report behind it
                if (send_now && item.tx_accept) begin
                    res0.kind    = KIND_FRAME;
                    res0.last    = !rpt_now;
                    res0.tx_id   = seq1[0] ? extended_id_reg : {18'd0, standard_id_reg};
                    res0.tx_ext  = seq1[0];
                    res0.tx_data = {seq1, TAIL_PATTERN};
                end
                if (rpt_now) begin
                    next_report_next = next_report_reg + report_period_reg;
                    res1.kind        = KIND_REPORT;
                    res1.last        = 1'b1;
                    res1.pass        = (count_ok_reg == sent_c) && (sent_c != 32'd0)
                                       && (count_bad_reg == 32'd0);
                    res1.period_sent = sent_c;
                    res1.period_ok   = count_ok_reg;
                    res1.period_lost = lost_c;
                    res1.period_bad  = count_bad_reg;
                    res1.total_ok    = sum_ok_reg;
                    res1.total_fail  = fail_c;
                    count_sent_next  = '0;
                    count_ok_next    = '0;
                    count_lost_next  = '0;
                    count_bad_next   = '0;
                end
                if (send_now && item.tx_accept) begin
                    push_n = rpt_now ? 2'd2 : 2'd1;
                end else if (rpt_now) begin
                    res0   = res1;
                    push_n = 2'd1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            send_period_reg   <= SEND_PERIOD_RST;
            reply_timeout_reg <= REPLY_TIMEOUT_RST;
            report_period_reg <= REPORT_PERIOD_RST;
            standard_id_reg   <= STANDARD_ID_RST;
            extended_id_reg   <= EXTENDED_ID_RST;
            tick_now_reg      <= '0;
            next_send_reg     <= {16'd0, SEND_PERIOD_RST};
            next_report_reg   <= REPORT_PERIOD_RST + {17'd0, SEND_PERIOD_RST[15:1]};
            sent_time_reg     <= '0;
            awaiting_reg      <= 1'b0;
            sequence_reg      <= '0;
            count_sent_reg    <= '0;
            count_ok_reg      <= '0;
            count_lost_reg    <= '0;
            count_bad_reg     <= '0;
            sum_ok_reg        <= '0;
            sum_fail_reg      <= '0;
        end else begin
            send_period_reg   <= send_period_next;
            reply_timeout_reg <= reply_timeout_next;
            report_period_reg <= report_period_next;
            standard_id_reg   <= standard_id_next;
            extended_id_reg   <= extended_id_next;
            tick_now_reg      <= tick_now_next;
            next_send_reg     <= next_send_next;
            next_report_reg   <= next_report_next;
            sent_time_reg     <= sent_time_next;
            awaiting_reg      <= awaiting_next;
            sequence_reg      <= sequence_next;
            count_sent_reg    <= count_sent_next;
            count_ok_reg      <= count_ok_next;
            count_lost_reg    <= count_lost_next;
            count_bad_reg     <= count_bad_next;
            sum_ok_reg        <= sum_ok_next;
            sum_fail_reg      <= sum_fail_next;
        end
    end

endmodule

// ----- rtl/core/can_loopback_self_test.sv -----
// Top level of the CAN loopback self-test: input register, engine, result queue.
//
// Input beats (s_*) are millisecond ticks (s_tuser = 0) or frames returned from
// the bus (s_tuser = 1). A tick beat may produce a test frame to transmit and
// a report, in that order; m_tuser tells them apart (0 frame, 1 report) and
// m_tlast marks the final result of a beat. A returned frame produces none.
// Configuration writes come on cfg_* (index 0..4 as in the register list,
// other indexes ignored) and are always ready; write only while idle.
// A beat taken into the input register is processed by the engine, which
// pushes its results into the result queue; the head result is on m_*.
// Throughput is one beat per cycle while the queue has room for two results;
// a tick with two results sends them in turn. A four-entry result queue sits
// between the engine and m_*, so a stalled receiver holds results there; the
// held beat waits, with s_tready low, until at least two entries are free.
// Reset (aresetn low, synchronous) restores the register defaults, clears
// all counters and time, drops any outstanding frame and empties the queue.
module can_loopback_self_test
    import cls_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // tx_accept, rx_id[29], rx_ext, rx_rtr, rx_len[4], rx_data[64], zero pad
    input  logic [S_TDATA_W-1:0] s_tdata,
    // mode
    input  logic                 s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // tx_id[29], tx_ext, tx_data[64], pass, period_sent, period_ok,
    // period_lost, period_bad, total_ok, total_fail (32 each), zero pad
    output logic [M_TDATA_W-1:0] m_tdata,
    // kind
    output logic                 m_tuser,
    output logic                 m_tlast,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [2:0]           cfg_index,
    input  logic [31:0]          cfg_data
);

    in_item_t   item_reg, item_next;
    logic       item_valid_reg, item_valid_next;
    logic       fire;
    logic       room2;
    logic       not_empty;
    logic [1:0] push_n;
    res_t       res0, res1, head;
    cfg_wr_t    cfg_wr;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = '{valid: cfg_valid, index: cfg_index, data: cfg_data};

    // Process the held beat when the queue can take two results
    assign fire     = item_valid_reg && room2;
    assign s_tready = !item_valid_reg || fire;

    // Capture a new beat
    always_comb begin
        item_next       = item_reg;
        item_valid_next = item_valid_reg && !fire;
        if (s_tvalid && s_tready) begin
            item_valid_next   = 1'b1;
            item_next.mode      = s_tuser;
            item_next.tx_accept = s_tdata[0];
            item_next.rx_id     = s_tdata[29:1];
            item_next.rx_ext    = s_tdata[30];
            item_next.rx_rtr    = s_tdata[31];
            item_next.rx_len    = s_tdata[35:32];
            item_next.rx_data   = s_tdata[99:36];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_valid_reg <= 1'b0;
        end else begin
            item_valid_reg <= item_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg <= item_next;
    end

    cls_engine u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg_wr  (cfg_wr),
        .fire    (fire),
        .item    (item_reg),
        .push_n  (push_n),
        .res0    (res0),
        .res1    (res1)
    );

    cls_res_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_n    (push_n),
        .push0     (res0),
        .push1     (res1),
        .pop       (m_tvalid && m_tready),
        .head      (head),
        .not_empty (not_empty),
        .room2     (room2)
    );

    // Present the head result
    assign m_tvalid = not_empty;
    assign m_tuser  = head.kind;
    assign m_tlast  = head.last;
    assign m_tdata  = {1'b0, head.total_fail, head.total_ok, head.period_bad,
                       head.period_lost, head.period_ok, head.period_sent,
                       head.pass, head.tx_data, head.tx_ext, head.tx_id};

endmodule

// ----- tb/sv/can_loopback_self_test_checker.sv -----
// Checker for the CAN loopback self-test: mirrors the engine and compares every result beat.
module can_loopback_self_test_checker
    import cls_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 s_tuser,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,
    input  logic                 m_tuser,
    input  logic                 m_tlast,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [2:0]           cfg_index,
    input  logic [31:0]          cfg_data,
    output logic [31:0]          mismatch_count,
    output logic [31:0]          results_owed
);

    localparam int SHOWN_MISMATCHES = 10;

    // Mirrored configuration registers
    logic [15:0] send_period;
    logic [15:0] reply_timeout;
    logic [31:0] report_period;
    logic [10:0] standard_id;
    logic [28:0] extended_id;

    // Mirrored schedule, outstanding frame and counters
    logic [31:0] tick_now;
    logic [31:0] next_send_at;
    logic [31:0] next_report_at;
    logic [31:0] sent_at;
    logic [31:0] seq_no;
    logic        awaiting_reply;
    logic [31:0] period_sent;
    logic [31:0] period_ok;
    logic [31:0] period_lost;
    logic [31:0] period_bad;
    logic [31:0] total_ok;
    logic [31:0] total_fail;

    // Results the block still owes, oldest first
    res_t owed_results[$];
    int   bad_fields;

    function automatic logic due_now(input logic [31:0] when);
        logic [31:0] diff;
        diff = tick_now - when;
        return !diff[31];
    endfunction

    function automatic logic [28:0] frame_id();
        return seq_no[0] ? extended_id : {18'd0, standard_id};
    endfunction

    task automatic rearm_schedules();
        next_send_at   = tick_now + {16'd0, send_period};
        next_report_at = tick_now + report_period + {17'd0, send_period[15:1]};
    endtask

    task automatic clear_all();
        send_period    = SEND_PERIOD_RST;
        reply_timeout  = REPLY_TIMEOUT_RST;
        report_period  = REPORT_PERIOD_RST;
        standard_id    = STANDARD_ID_RST;
        extended_id    = EXTENDED_ID_RST;
        tick_now       = '0;
        rearm_schedules();
        sent_at        = '0;
        seq_no         = '0;
        awaiting_reply = 1'b0;
        period_sent    = '0;
        period_ok      = '0;
        period_lost    = '0;
        period_bad     = '0;
        total_ok       = '0;
        total_fail     = '0;
    endtask

    task automatic write_register(input logic [2:0] index, input logic [31:0] value);
        case (index)
            REG_SEND_PERIOD: begin
                send_period = value[15:0];
                rearm_schedules();
            end
            REG_REPLY_TIMEOUT: reply_timeout = value[15:0];
            REG_REPORT_PERIOD: begin
                report_period = value;
                rearm_schedules();
            end
            REG_STANDARD_ID: standard_id = value[10:0];
            REG_EXTENDED_ID: extended_id = value[28:0];
            default: ;
        endcase
    endtask

    // Advance time by one tick and queue the frame and report it causes
    task automatic advance_tick(input logic tx_accept);
        res_t frame_r;
        res_t report_r;
        logic has_frame;
        logic has_report;
        frame_r    = '0;
        report_r   = '0;
        has_frame  = 1'b0;
        has_report = 1'b0;
        tick_now++;

        // Time out the outstanding frame
        if (awaiting_reply && (tick_now - sent_at) >= {16'd0, reply_timeout}) begin
            awaiting_reply = 1'b0;
            period_lost++;
            total_fail++;
        end

        // Build the next test frame; a refused send counts as lost
        if (!awaiting_reply && due_now(next_send_at)) begin
            next_send_at = next_send_at + {16'd0, send_period};
            seq_no++;
            period_sent++;
            if (tx_accept) begin
                has_frame       = 1'b1;
                frame_r.kind    = KIND_FRAME;
                frame_r.tx_id   = frame_id();
                frame_r.tx_ext  = seq_no[0];
                frame_r.tx_data = {seq_no, TAIL_PATTERN};
                awaiting_reply  = 1'b1;
                sent_at         = tick_now;
            end else begin
                period_lost++;
                total_fail++;
            end
        end

        // Report and clear the period counts
        if (due_now(next_report_at)) begin
            next_report_at       = next_report_at + report_period;
            has_report           = 1'b1;
            report_r.kind        = KIND_REPORT;
            report_r.pass        = (period_ok == period_sent) && (period_sent != 0)
                                   && (period_bad == 0);
            report_r.period_sent = period_sent;
            report_r.period_ok   = period_ok;
            report_r.period_lost = period_lost;
            report_r.period_bad  = period_bad;
            report_r.total_ok    = total_ok;
            report_r.total_fail  = total_fail;
            period_sent          = '0;
            period_ok            = '0;
            period_lost          = '0;
            period_bad           = '0;
        end

        if (has_report)
            report_r.last = 1'b1;
        else
            frame_r.last = 1'b1;
        if (has_frame)
            owed_results.push_back(frame_r);
        if (has_report)
            owed_results.push_back(report_r);
    endtask

    // Judge a frame returned from the bus against the outstanding one
    task automatic judge_frame(input logic [28:0] id, input logic ext, input logic rtr,
                               input logic [3:0] len, input logic [63:0] data);
        if (!awaiting_reply) begin
            period_bad++;
        end else begin
            if (id == frame_id() && ext == seq_no[0] && !rtr && len == FRAME_LEN
                    && data == {seq_no, TAIL_PATTERN}) begin
                period_ok++;
                total_ok++;
            end else begin
                period_bad++;
                total_fail++;
            end
            awaiting_reply = 1'b0;
        end
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            bad_fields++;
            if (bad_fields <= SHOWN_MISMATCHES)
                $display("mismatch in %s: expected %h, got %h", name, want, got);
        end
    endtask

    always @(posedge aclk) begin
        res_t want;
        res_t got;
        if (!aresetn) begin
            clear_all();
            owed_results.delete();
            bad_fields = 0;
        end else begin
            if (cfg_valid && cfg_ready)
                write_register(cfg_index, cfg_data);

            // Predict from each accepted input beat
            if (s_tvalid && s_tready) begin
                if (s_tuser == MODE_FRAME)
                    judge_frame(s_tdata[29:1], s_tdata[30], s_tdata[31], s_tdata[35:32],
                                s_tdata[99:36]);
                else
                    advance_tick(s_tdata[0]);
            end

            // Compare each accepted result beat with the oldest owed result
            if (m_tvalid && m_tready) begin
                got.kind        = m_tuser;
                got.last        = m_tlast;
                got.tx_id       = m_tdata[28:0];
                got.tx_ext      = m_tdata[29];
                got.tx_data     = m_tdata[93:30];
                got.pass        = m_tdata[94];
                got.period_sent = m_tdata[126:95];
                got.period_ok   = m_tdata[158:127];
                got.period_lost = m_tdata[190:159];
                got.period_bad  = m_tdata[222:191];
                got.total_ok    = m_tdata[254:223];
                got.total_fail  = m_tdata[286:255];
                if (owed_results.size() == 0) begin
                    bad_fields++;
                    if (bad_fields <= SHOWN_MISMATCHES)
                        $display("unexpected result beat: kind %b, data %h", m_tuser, m_tdata);
                end else begin
                    want = owed_results.pop_front();
                    check_field("kind", 64'(want.kind), 64'(got.kind));
                    check_field("last", 64'(want.last), 64'(got.last));
                    check_field("tx_id", 64'(want.tx_id), 64'(got.tx_id));
                    check_field("tx_ext", 64'(want.tx_ext), 64'(got.tx_ext));
                    check_field("tx_data", want.tx_data, got.tx_data);
                    check_field("pass", 64'(want.pass), 64'(got.pass));
                    check_field("period_sent", 64'(want.period_sent), 64'(got.period_sent));
                    check_field("period_ok", 64'(want.period_ok), 64'(got.period_ok));
                    check_field("period_lost", 64'(want.period_lost), 64'(got.period_lost));
                    check_field("period_bad", 64'(want.period_bad), 64'(got.period_bad));
                    check_field("total_ok", 64'(want.total_ok), 64'(got.total_ok));
                    check_field("total_fail", 64'(want.total_fail), 64'(got.total_fail));
                end
            end
        end
        mismatch_count <= bad_fields;
        results_owed   <= owed_results.size();
    end

endmodule

// ----- tb/sv/can_loopback_self_test_tb.sv -----
// Testbench top for the CAN loopback self-test: stimulus, receiver stalls and verdict.
module can_loopback_self_test_tb;
    import cls_pkg::*;

    // Longest legal quiet stretch is a sender gap plus a receiver stall run
    localparam int IDLE_LIMIT = 2000;

    // Ways to spoil a frame before returning it
    localparam int ECHO_EXACT      = 0;
    localparam int ECHO_BAD_ID     = 1;
    localparam int ECHO_BAD_FORMAT = 2;
    localparam int ECHO_REMOTE     = 3;
    localparam int ECHO_BAD_LEN    = 4;
    localparam int ECHO_BAD_DATA   = 5;

    // Receiver stall patterns
    localparam int DRAIN_FREE   = 0;
    localparam int DRAIN_RANDOM = 1;
    localparam int DRAIN_FOURTH = 2;
    localparam int DRAIN_RUNS   = 3;

    typedef struct packed {
        logic [28:0] id;
        logic        ext;
        logic [63:0] data;
    } sent_frame_t;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 s_tuser;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;
    logic                 m_tlast;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [2:0]           cfg_index;
    logic [31:0]          cfg_data;
    logic [31:0]          mismatch_count;
    logic [31:0]          results_owed;

    sent_frame_t on_bus[$];
    int          burst_left = 0;
    int          idle_cycles = 0;
    int          drain_mode = DRAIN_FREE;
    int          drain_left = 0;
    int          run_left = 0;
    logic        run_high = 1'b1;
    int          drain_count = 0;

    can_loopback_self_test dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    can_loopback_self_test_checker chk (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .m_tlast        (m_tlast),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .results_owed   (results_owed)
    );

    always #5 aclk = ~aclk;

    // Stall the result channel on a changing pattern
    always @(posedge aclk) begin
        if (drain_left == 0) begin
            drain_mode = $urandom_range(DRAIN_FREE, DRAIN_RUNS);
            drain_left = $urandom_range(30, 300);
        end else begin
            drain_left--;
        end
        drain_count++;
        case (drain_mode)
            DRAIN_FREE:   m_tready <= 1'b1;
            DRAIN_RANDOM: m_tready <= ($urandom_range(0, 9) < 6);
            DRAIN_FOURTH: m_tready <= (drain_count % 4 == 0);
            default: begin
                if (run_left == 0) begin
                    run_high = !run_high;
                    run_left = run_high ? $urandom_range(1, 4) : $urandom_range(5, 20);
                end else begin
                    run_left--;
                end
                m_tready <= run_high;
            end
        endcase
    end

    // Collect transmitted test frames so they can be looped back
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready && m_tuser == KIND_FRAME)
            on_bus.push_back({m_tdata[28:0], m_tdata[29], m_tdata[93:30]});
    end

    // End the run when nothing moves for too long
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic logic [S_TDATA_W-1:0] frame_beat(
        input logic accept, input logic [28:0] id, input logic ext, input logic rtr,
        input logic [3:0] len, input logic [63:0] data);
        return {4'd0, data, len, rtr, ext, id, accept};
    endfunction

    // Offer one beat, with a random gap between bursts
    task automatic put_beat(input logic mode, input logic [S_TDATA_W-1:0] data);
        int gap;
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            gap = $urandom_range(1, 12);
            repeat (gap) @(posedge aclk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                      : $urandom_range(1, 20);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= data;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Tick with random content in the ignored frame fields
    task automatic send_tick(input logic accept);
        put_beat(MODE_TICK, frame_beat(accept, 29'($urandom), 1'($urandom_range(0, 1)),
                 1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)), {$urandom, $urandom}));
    endtask

    task automatic send_noise_frame();
        put_beat(MODE_FRAME, frame_beat(1'($urandom_range(0, 1)), 29'($urandom),
                 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                 4'($urandom_range(0, 15)), {$urandom, $urandom}));
    endtask

    // Loop back the oldest transmitted frame, spoiled as asked
    task automatic return_frame(input int fault);
        sent_frame_t f;
        logic        rtr;
        logic [3:0]  len;
        if (on_bus.size() == 0) begin
            s_tvalid <= 1'b0;
            while (on_bus.size() == 0) @(posedge aclk);
        end
        f   = on_bus.pop_front();
        rtr = 1'b0;
        len = FRAME_LEN;
        case (fault)
            ECHO_BAD_ID:     f.id = f.id ^ (29'd1 << $urandom_range(0, 28));
            ECHO_BAD_FORMAT: f.ext = !f.ext;
            ECHO_REMOTE:     rtr = 1'b1;
            ECHO_BAD_LEN: begin
                len = 4'($urandom_range(0, 14));
                if (len >= FRAME_LEN)
                    len = len + 4'd1;
            end
            ECHO_BAD_DATA:   f.data = f.data ^ (64'd1 << $urandom_range(0, 63));
            default: ;
        endcase
        put_beat(MODE_FRAME, frame_beat(1'($urandom_range(0, 1)), f.id, f.ext, rtr, len,
                 f.data));
    endtask

    // Wait until every owed result is out and the engine has drained
    task automatic settle();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (results_owed != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic cfg_write(input logic [2:0] index, input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    // Write all registers while idle; fill unused upper bits with noise
    task automatic program_regs(input logic [15:0] send_p, input logic [15:0] timeout,
                                input logic [31:0] report_p, input logic [10:0] std_id,
                                input logic [28:0] ext_id);
        settle();
        cfg_write(REG_STANDARD_ID, {21'($urandom), std_id});
        cfg_write(REG_EXTENDED_ID, {3'($urandom), ext_id});
        cfg_write(REG_REPLY_TIMEOUT, {16'($urandom), timeout});
        cfg_write(REG_REPORT_PERIOD, report_p);
        cfg_write(REG_SEND_PERIOD, {16'($urandom), send_p});
        cfg_write(3'($urandom_range(REG_EXTENDED_ID + 1, 7)), $urandom);
        cfg_valid <= 1'b0;
    endtask

    // Mostly ticks and looped-back frames, some spoiled, plus noise frames
    task automatic run_random(input int count);
        int roll;
        for (int k = 0; k < count; k++) begin
            roll = $urandom_range(0, 99);
            if (roll < 40 && on_bus.size() != 0) begin
                if ($urandom_range(0, 3) == 0)
                    return_frame($urandom_range(ECHO_BAD_ID, ECHO_BAD_DATA));
                else
                    return_frame(ECHO_EXACT);
            end else if (roll < 48) begin
                send_noise_frame();
            end else begin
                send_tick($urandom_range(0, 9) != 0);
            end
        end
    endtask

    initial begin
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= MODE_TICK;
        cfg_valid <= 1'b0;
        cfg_index <= REG_SEND_PERIOD;
        cfg_data  <= '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Short schedule, all-ones IDs: unexpected frame, match, refusal, remote reply, timeout, stale reply
        program_regs(16'd2, 16'd3, 32'd5, 11'h7FF, 29'h1FFF_FFFF);
        send_noise_frame();
        send_tick(1'b1);
        send_tick(1'b1);
        return_frame(ECHO_EXACT);
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b1);
        send_tick(1'b1);
        return_frame(ECHO_REMOTE);
        send_tick(1'b1);
        send_tick(1'b1);
        send_tick(1'b1);
        send_tick(1'b1);
        send_tick(1'b1);
        return_frame(ECHO_EXACT);
        return_frame(ECHO_EXACT);

        // All-zero registers: send and report on every tick, immediate timeout
        program_regs(16'd0, 16'd0, 32'd0, 11'd0, 29'd0);
        on_bus.delete();
        send_tick(1'b1);
        return_frame(ECHO_EXACT);
        send_tick(1'b1);
        send_tick(1'b1);
        send_tick(1'b0);
        send_noise_frame();

        // Random phases over several settings
        program_regs(16'd4, 16'd30, 32'd40, 11'($urandom), 29'($urandom));
        run_random(160);
        program_regs(16'd1, 16'hFFFF, 32'd25, 11'd0, 29'd0);
        run_random(150);
        program_regs(16'd0, 16'd0, 32'd0, 11'h7FF, 29'h1FFF_FFFF);
        run_random(100);
        program_regs(16'hFFFF, 16'd1, 32'hFFFF_FFFF, 11'($urandom), 29'($urandom));
        run_random(40);
        program_regs(16'd2, 16'd5, 32'hFFFF_FFFF, 11'h7FF, 29'h1FFF_FFFF);
        run_random(100);
        repeat (3) begin
            program_regs(16'($urandom_range(0, 12)), 16'($urandom_range(0, 40)),
                         32'($urandom_range(0, 80)), 11'($urandom), 29'($urandom));
            run_random(110);
        end

        // Drain and decide
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (results_owed != 0);
        repeat (8) @(posedge aclk);
        if (mismatch_count == 0 && results_owed == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
